FILE: design/tcm_pkg.sv
// shared constants, types and helpers of the threshold crossing monitor
package tcm_pkg;

   localparam int CHANNELS          = 8;
   localparam int SLOTS_PER_CHANNEL = 4;
   localparam int SAMPLE_BITS       = 10;
   localparam int MAX_RESULTS       = 4;

   localparam int CHANNEL_BITS = 3;
   localparam int SLOT_BITS    = 2;
   localparam int COND_BITS    = 2;
   localparam int TOTAL_SLOTS  = CHANNELS * SLOTS_PER_CHANNEL;
   localparam int INDEX_BITS   = $clog2(TOTAL_SLOTS);
   localparam int HITS_BITS    = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS_PER_CHANNEL - 1);

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_RULE   = 1'b1
   } kind_type;

   typedef enum logic [COND_BITS-1:0] {
      COND_OFF  = 2'd0,
      COND_FALL = 2'd1,
      COND_RISE = 2'd2
   } cond_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_EMIT = 2'd2
   } back_state_type;

   // classified word handed from front to back
   typedef struct packed {
      kind_type                kind;
      logic [CHANNEL_BITS-1:0] channel;
      logic [SLOT_BITS-1:0]    slot;
      cond_type                condition;
      logic [SAMPLE_BITS-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] hit_channel;
      logic [SLOT_BITS-1:0]    hit_slot;
      logic [COND_BITS-1:0]    hit_direction;
      logic [SAMPLE_BITS-1:0]  hit_threshold;
      logic [SAMPLE_BITS-1:0]  old_reading;
      logic [SAMPLE_BITS-1:0]  new_reading;
      logic                    last;
   } rsp_word_type;

   function automatic logic [INDEX_BITS-1:0] slot_index(
      input logic [CHANNEL_BITS-1:0] channel,
      input logic [SLOT_BITS-1:0]    slot
   );
      logic [INDEX_BITS+CHANNEL_BITS-1:0] full;
      full = (INDEX_BITS+CHANNEL_BITS)'(channel) * (INDEX_BITS+CHANNEL_BITS)'(SLOTS_PER_CHANNEL)
           + (INDEX_BITS+CHANNEL_BITS)'(slot);
      return full[INDEX_BITS-1:0];
   endfunction

endpackage

FILE: design/tcm_if.sv
// valid/ready channel interfaces for request and notification words
interface tcm_req_if;
   import tcm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    action;
   logic [CHANNEL_BITS-1:0] channel;
   logic [SLOT_BITS-1:0]    slot;
   logic [SAMPLE_BITS-1:0]  sample_value;
   logic [COND_BITS-1:0]    rule_condition;
   logic [SAMPLE_BITS-1:0]  rule_threshold;

   modport source (
      output valid, action, channel, slot, sample_value, rule_condition, rule_threshold,
      input  ready
   );
   modport sink (
      input  valid, action, channel, slot, sample_value, rule_condition, rule_threshold,
      output ready
   );
endinterface

interface tcm_rsp_if;
   import tcm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] hit_channel;
   logic [SLOT_BITS-1:0]    hit_slot;
   logic [COND_BITS-1:0]    hit_direction;
   logic [SAMPLE_BITS-1:0]  hit_threshold;
   logic [SAMPLE_BITS-1:0]  old_reading;
   logic [SAMPLE_BITS-1:0]  new_reading;
   logic                    last;

   modport source (
      output valid, hit_channel, hit_slot, hit_direction, hit_threshold,
             old_reading, new_reading, last,
      input  ready
   );
   modport sink (
      input  valid, hit_channel, hit_slot, hit_direction, hit_threshold,
             old_reading, new_reading, last,
      output ready
   );
endinterface

FILE: design/tcm_front.sv
// front end: accepts request words, drops out of range ones, classifies the rest
module tcm_front (
   input  logic             clock,
   input  logic             reset,
   tcm_req_if.sink          req,
   output logic             push_valid,
   output tcm_pkg::cmd_type push_cmd,
   input  logic             q_full
);
   import tcm_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_ff, hold_in;
   cmd_type cls;
   logic    in_range;
   logic    accept;
   logic    pushed;

   always_comb begin
      cls.kind    = req.action ? KIND_RULE : KIND_SAMPLE;
      cls.channel = req.channel;
      cls.slot    = req.slot;
      cls.value   = req.action ? req.rule_threshold : req.sample_value;
      case (req.rule_condition)
         COND_FALL: cls.condition = COND_FALL;
         COND_RISE: cls.condition = COND_RISE;
         default:   cls.condition = COND_OFF;
      endcase
      in_range = (int'(req.channel) < CHANNELS)
              && (!req.action || (int'(req.slot) < SLOTS_PER_CHANNEL));
   end

   assign pushed     = hold_valid_ff && !q_full;
   assign req.ready  = !hold_valid_ff || !q_full;
   assign accept     = req.valid && req.ready;
   assign push_valid = hold_valid_ff;
   assign push_cmd   = hold_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (accept) begin
         hold_valid_in = in_range;
         hold_in       = cls;
      end else if (pushed) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

FILE: design/tcm_queue.sv
// short queue of classified words between front and back
module tcm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  tcm_pkg::cmd_type push_cmd,
   output logic             full,
   output logic             head_valid,
   output tcm_pkg::cmd_type head,
   input  logic             pop
);
   import tcm_pkg::*;

   cmd_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   push_en;
   logic                   pop_en;

   assign full       = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];
   assign push_en    = push_valid && !full;
   assign pop_en     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_en, pop_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: design/tcm_back.sv
// back end: rule tables, stored readings, slot scan and notification register
module tcm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  tcm_pkg::cmd_type head,
   output logic             pop,
   tcm_rsp_if.source        rsp
);
   import tcm_pkg::*;

   back_state_type               state_ff, state_in;
   cmd_type                      cur_ff, cur_in;
   logic [SAMPLE_BITS-1:0]       old_ff, old_in;
   logic [SLOT_BITS-1:0]         slot_ff, slot_in;
   logic [SLOTS_PER_CHANNEL-1:0] mask_ff, mask_in;
   logic [HITS_BITS-1:0]         hits_ff, hits_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_word_type                 rsp_ff, rsp_in;

   cond_type                     cond_ff [TOTAL_SLOTS];
   logic [SAMPLE_BITS-1:0]       thr_ff [TOTAL_SLOTS];
   logic [SAMPLE_BITS-1:0]       prev_ff [CHANNELS];
   logic [CHANNELS-1:0]          seen_ff;

   logic [INDEX_BITS-1:0]        idx;
   logic [INDEX_BITS-1:0]        rule_idx;
   cond_type                     cur_cond;
   logic [SAMPLE_BITS-1:0]       cur_thr;
   logic                         fire;
   logic                         out_free;
   logic                         advance;
   logic [SLOTS_PER_CHANNEL-1:0] above;
   logic                         is_last;
   logic                         head_seen;
   logic                         rule_we;
   logic                         store_we;
   logic [CHANNEL_BITS-1:0]      store_ch;
   logic [SAMPLE_BITS-1:0]       store_val;

   assign idx       = slot_index(cur_ff.channel, slot_ff);
   assign rule_idx  = slot_index(head.channel, head.slot);
   assign cur_cond  = cond_ff[idx];
   assign cur_thr   = thr_ff[idx];
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign advance   = !mask_ff[slot_ff] || out_free;
   assign head_seen = seen_ff[head.channel];

   always_comb begin
      case (cur_cond)
         COND_FALL: fire = (old_ff > cur_thr) && (cur_ff.value <= cur_thr);
         COND_RISE: fire = (old_ff < cur_thr) && (cur_ff.value >= cur_thr);
         default:   fire = 1'b0;
      endcase
      for (int i = 0; i < SLOTS_PER_CHANNEL; i++) begin
         above[i] = (SLOT_BITS'(i) > slot_ff);
      end
      is_last = ~|(mask_ff & above);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid && head.kind == KIND_SAMPLE && head_seen) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (slot_ff == LAST_SLOT) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (advance && slot_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop          = 1'b0;
      cur_in       = cur_ff;
      old_in       = old_ff;
      slot_in      = slot_ff;
      mask_in      = mask_ff;
      hits_in      = hits_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in       = rsp_ff;
      rule_we      = 1'b0;
      store_we     = 1'b0;
      store_ch     = cur_ff.channel;
      store_val    = cur_ff.value;
      case (state_ff)
         ST_IDLE: begin
            pop = head_valid;
            if (head_valid) begin
               cur_in  = head;
               old_in  = prev_ff[head.channel];
               slot_in = '0;
               mask_in = '0;
               hits_in = '0;
               if (head.kind == KIND_RULE) begin
                  rule_we = 1'b1;
               end else if (!head_seen) begin
                  store_we  = 1'b1;
                  store_ch  = head.channel;
                  store_val = head.value;
               end
            end
         end
         ST_SCAN: begin
            if (fire && hits_ff < HITS_BITS'(MAX_RESULTS)) begin
               mask_in[slot_ff] = 1'b1;
               hits_in          = hits_ff + 1'b1;
            end
            slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
         end
         ST_EMIT: begin
            if (advance) begin
               if (mask_ff[slot_ff]) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.hit_channel   = cur_ff.channel;
                  rsp_in.hit_slot      = slot_ff;
                  rsp_in.hit_direction = cur_cond;
                  rsp_in.hit_threshold = cur_thr;
                  rsp_in.old_reading   = old_ff;
                  rsp_in.new_reading   = cur_ff.value;
                  rsp_in.last          = is_last;
               end
               if (slot_ff == LAST_SLOT) begin
                  slot_in  = '0;
                  store_we = 1'b1;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (store_we) begin
            seen_ff[store_ch] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      old_ff  <= old_in;
      slot_ff <= slot_in;
      mask_ff <= mask_in;
      hits_ff <= hits_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_SLOTS; i++) begin
            cond_ff[i] <= COND_OFF;
         end
      end else if (rule_we) begin
         cond_ff[rule_idx] <= head.condition;
      end
   end

   always_ff @(posedge clock) begin
      if (rule_we) begin
         thr_ff[rule_idx] <= head.value;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         prev_ff[store_ch] <= store_val;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.hit_channel   = rsp_ff.hit_channel;
   assign rsp.hit_slot      = rsp_ff.hit_slot;
   assign rsp.hit_direction = rsp_ff.hit_direction;
   assign rsp.hit_threshold = rsp_ff.hit_threshold;
   assign rsp.old_reading   = rsp_ff.old_reading;
   assign rsp.new_reading   = rsp_ff.new_reading;
   assign rsp.last          = rsp_ff.last;

endmodule

FILE: design/threshold_crossing_monitor.sv
// top level of the multichannel threshold crossing monitor
//
// req_ch takes one word per valid/ready handshake: either a sample for a
// channel or a write of one rule slot (condition and threshold). rsp_ch
// gives one notification word per firing slot, the final one of a sample
// marked with last. Rule writes and a channel's first sample give nothing.
// A word is registered in the front, passes a two-entry queue and is then
// carried out by the back, so the request side keeps taking words while a
// notification waits on rsp_ch.
// A rule write or first sample occupies the back for its pick-up step
// only. Any other sample passes a pick-up step, a scan of the rule table
// slot by slot, and an emit pass over the slots, during which the back
// holds while a firing slot's notification cannot leave; the reading is
// stored as the emit pass leaves the last slot.
// When rsp_ch stalls, the back holds on the waiting notification, the
// queue fills and req_ch drops ready. Synchronous reset disables every
// rule slot and forgets all stored readings; nothing waits in any stage.
module threshold_crossing_monitor (
   input logic       clock,
   input logic       reset,
   tcm_req_if.sink   req_ch,
   tcm_rsp_if.source rsp_ch
);
   import tcm_pkg::*;

   logic    push_valid;
   cmd_type push_cmd;
   logic    q_full;
   logic    head_valid;
   cmd_type head;
   logic    pop;

   tcm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .q_full     (q_full)
   );

   tcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   tcm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp_ch)
   );

endmodule
